// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i while out of reset.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge of clk_i, reset or not.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/bss_pkg.sv =====
`default_nettype none

package bss_pkg;

  localparam int DepthDef     = 16;
  localparam int ItemWidthDef = 32;

  // fixed field widths
  localparam int OpW       = 3;
  localparam int PosW      = 4;
  localparam int ReadW     = 32;
  localparam int IdxW      = 4;
  localparam int CntOutW   = 5;
  localparam int MTdataW   = 48;

  typedef enum logic [OpW-1:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE         = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_e;

  // per-cell update command
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

  // per-cell compare against the key
  typedef struct packed {
    logic ge;
    logic eq;
  } cell_flag_t;

endpackage

`default_nettype wire

// ===== src/bounded_sorted_sequence.sv =====
// Channel  Dir  tdata fields (lowest bit up)                                  Width
// s_axis   in   operation[2:0] position[6:3] item_value[ItemWidth+6:7]        bytes
// m_axis   out  ok, read_value, found_index, removed_count, length_now,       48
//               is_empty
//
// For each item, the accept cycle registers every cell's compare flags, and the
// EXEC state then applies the update across the cell row and loads the result.
// remove_all repeats passes until no match is left: each pass erases the first
// match and recompares the row. Reset clears the length; no clearing pass.
// A finished update holds in place while the output register is full and stalled.
`default_nettype none

`include "assert_macros.svh"

module bounded_sorted_sequence #(
  parameter int Depth     = bss_pkg::DepthDef,
  parameter int ItemWidth = bss_pkg::ItemWidthDef,
  localparam int InW      = bss_pkg::OpW + bss_pkg::PosW + ItemWidth,
  localparam int STdataW  = ((InW + 7) / 8) * 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // operation, position, item_value
  input  wire logic [STdataW-1:0]          s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // ok, read_value, found_index, removed_count, length_now, is_empty
  output logic [bss_pkg::MTdataW-1:0]      m_axis_tdata
);

  localparam int CntW = $clog2(Depth + 1);
  localparam int IdxW = $clog2(Depth);

  bss_pkg::state_e state_q, state_d;

  logic [bss_pkg::OpW-1:0]  op_q, op_d, cur_op;
  logic [bss_pkg::PosW-1:0] pos_q, pos_d, cur_pos;
  logic [ItemWidth-1:0]     val_q, val_d, key;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          removed_q, removed_d;
  logic [Depth-1:0]         flags_q, flags_d;
  logic                     flags_en;

  logic                     out_valid_q, out_load;
  logic [bss_pkg::MTdataW-1:0] out_data_q, out_data_d;

  logic [bss_pkg::OpW-1:0]  in_op;
  logic [bss_pkg::PosW-1:0] in_pos;
  logic [ItemWidth-1:0]     in_val;
  logic                     in_accept;

  logic [ItemWidth-1:0]     cell_val [Depth];
  bss_pkg::cell_flag_t      cell_flag [Depth];
  bss_pkg::cell_ctrl_t      cell_ctrl [Depth];

  logic [Depth-1:0] span, span_lo, first;
  logic [Depth-1:0] load_v, left_v, right_v;
  logic             any, full, pos_le, pos_lt;
  logic             do_inc, do_dec, do_rem, finish, exec_go, in_exec;
  logic             ok_x;
  logic [ItemWidth-1:0] sel_val;
  logic [IdxW-1:0]  enc;

  assign in_op     = s_axis_tdata[bss_pkg::OpW-1:0];
  assign in_pos    = s_axis_tdata[bss_pkg::OpW +: bss_pkg::PosW];
  assign in_val    = s_axis_tdata[bss_pkg::OpW + bss_pkg::PosW +: ItemWidth];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // compare against the incoming beat while idle, else against the held key
  assign cur_op  = (state_q == bss_pkg::ST_IDLE) ? in_op  : op_q;
  assign cur_pos = (state_q == bss_pkg::ST_IDLE) ? in_pos : pos_q;
  assign key     = (state_q == bss_pkg::ST_IDLE) ? in_val : val_q;

  // cell row
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    bss_cell #(
      .ItemWidth (ItemWidth)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[g]),
      .key_i   (key),
      .left_i  ((g == 0) ? '0 : cell_val[(g == 0) ? 0 : g - 1]),
      .right_i ((g == Depth - 1) ? cell_val[g] : cell_val[(g == Depth - 1) ? g : g + 1]),
      .value_o (cell_val[g]),
      .flag_o  (cell_flag[g])
    );
    assign cell_ctrl[g].load       = load_v[g];
    assign cell_ctrl[g].take_left  = left_v[g];
    assign cell_ctrl[g].take_right = right_v[g];
  end

  // flags that mark where the operation acts
  always_comb begin
    flags_d = '0;
    for (int i = 0; i < Depth; i++) begin
      case (cur_op)
        bss_pkg::OP_INSERT_SORTED: begin
          flags_d[i] = (cell_flag[i].ge && (i < int'(count_q))) || (i >= int'(count_q));
        end
        bss_pkg::OP_REMOVE_ALL, bss_pkg::OP_FIND: begin
          flags_d[i] = cell_flag[i].eq && (i < int'(count_q));
        end
        bss_pkg::OP_INSERT_AT, bss_pkg::OP_ERASE, bss_pkg::OP_GET, bss_pkg::OP_SET: begin
          flags_d[i] = (int'(cur_pos) == i);
        end
        default: begin
          flags_d[i] = 1'b0;
        end
      endcase
    end
  end

  assign flags_en = in_accept || (state_q == bss_pkg::ST_CMP);

  // span: every cell at or above the lowest flag
  assign span    = flags_q | ~(flags_q - Depth'(1));
  assign span_lo = span << 1;
  assign first   = span & ~span_lo;
  assign any     = |flags_q;
  assign full    = int'(count_q) >= Depth;
  assign pos_le  = int'(pos_q) <= int'(count_q);
  assign pos_lt  = int'(pos_q) < int'(count_q);
  assign in_exec = (state_q == bss_pkg::ST_EXEC);

  always_comb begin
    sel_val = '0;
    enc     = '0;
    for (int i = 0; i < Depth; i++) begin
      sel_val = sel_val | (cell_val[i] & {ItemWidth{flags_q[i]}});
      if (first[i]) begin
        enc = enc | IdxW'(i);
      end
    end
  end

  assign finish  = !((op_q == bss_pkg::OP_REMOVE_ALL) && any);
  assign exec_go = in_exec && (!finish || !out_valid_q || m_axis_tready);

  // update decode
  always_comb begin
    load_v  = '0;
    left_v  = '0;
    right_v = '0;
    do_inc  = 1'b0;
    do_dec  = 1'b0;
    do_rem  = 1'b0;
    ok_x    = 1'b0;
    case (op_q)
      bss_pkg::OP_INSERT_AT, bss_pkg::OP_INSERT_SORTED: begin
        if (!full && (pos_le || (op_q == bss_pkg::OP_INSERT_SORTED))) begin
          load_v = first;
          left_v = span_lo;
          do_inc = 1'b1;
          ok_x   = 1'b1;
        end
      end
      bss_pkg::OP_ERASE: begin
        if (pos_lt) begin
          right_v = span;
          do_dec  = 1'b1;
          ok_x    = 1'b1;
        end
      end
      bss_pkg::OP_REMOVE_ALL: begin
        if (any) begin
          right_v = span;
          do_dec  = 1'b1;
          do_rem  = 1'b1;
        end
        ok_x = (removed_q != '0);
      end
      bss_pkg::OP_GET: begin
        ok_x = pos_lt;
      end
      bss_pkg::OP_SET: begin
        if (pos_lt) begin
          load_v = flags_q;
          ok_x   = 1'b1;
        end
      end
      bss_pkg::OP_FIND: begin
        ok_x = any;
      end
      default: begin
        ok_x = 1'b0;
      end
    endcase
    // hold the row while the result cannot leave
    if (!exec_go) begin
      load_v  = '0;
      left_v  = '0;
      right_v = '0;
      do_inc  = 1'b0;
      do_dec  = 1'b0;
      do_rem  = 1'b0;
    end
  end

  always_comb begin
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    count_d   = count_q;
    removed_d = removed_q;
    if (in_accept) begin
      op_d      = in_op;
      pos_d     = in_pos;
      val_d     = in_val;
      removed_d = '0;
    end
    if (do_inc) begin
      count_d = count_q + CntW'(1);
    end else if (do_dec) begin
      count_d = count_q - CntW'(1);
    end
    if (do_rem) begin
      removed_d = removed_q + CntW'(1);
    end
  end

  assign out_load = exec_go && finish;

  // length and emptiness report the count after this update
  always_comb begin
    out_data_d = '0;
    out_data_d[0] = ok_x;
    if ((op_q == bss_pkg::OP_GET) && ok_x) begin
      out_data_d[1 +: bss_pkg::ReadW] = bss_pkg::ReadW'(sel_val);
    end
    if ((op_q == bss_pkg::OP_FIND) && ok_x) begin
      out_data_d[1 + bss_pkg::ReadW +: bss_pkg::IdxW] = bss_pkg::IdxW'(enc);
    end
    out_data_d[1 + bss_pkg::ReadW + bss_pkg::IdxW +: bss_pkg::CntOutW] =
      bss_pkg::CntOutW'(removed_q);
    out_data_d[1 + bss_pkg::ReadW + bss_pkg::IdxW + bss_pkg::CntOutW +: bss_pkg::CntOutW] =
      bss_pkg::CntOutW'(count_d);
    out_data_d[bss_pkg::MTdataW-1] = (count_d == '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bss_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = bss_pkg::ST_EXEC;
        end
      end
      bss_pkg::ST_CMP: begin
        state_d = bss_pkg::ST_EXEC;
      end
      bss_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_d = finish ? bss_pkg::ST_IDLE : bss_pkg::ST_CMP;
        end
      end
      default: begin
        state_d = bss_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == bss_pkg::ST_IDLE);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bss_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    removed_q <= removed_d;
    if (flags_en) begin
      flags_q <= flags_d;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, !rst_ni || (int'(count_q) <= Depth), "length exceeds depth")
  `ASSERT_RUN(a_count_step, (count_q != $past(count_q)) |-> $past(state_q == bss_pkg::ST_EXEC), "length changed outside update")
  `ASSERT_RUN(a_out_from_exec, $rose(out_valid_q) |-> $past(state_q == bss_pkg::ST_EXEC), "result loaded outside update")

endmodule

`default_nettype wire

// ===== src/bss_cell.sv =====
`default_nettype none

module bss_cell #(
  parameter int ItemWidth = bss_pkg::ItemWidthDef
) (
  input  wire logic                 clk_i,
  input  wire bss_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [ItemWidth-1:0] key_i,
  input  wire logic [ItemWidth-1:0] left_i,
  input  wire logic [ItemWidth-1:0] right_i,
  output logic [ItemWidth-1:0]      value_o,
  output bss_pkg::cell_flag_t       flag_o
);

  logic [ItemWidth-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = key_i;
    end else if (ctrl_i.take_left) begin
      value_d = left_i;
    end else if (ctrl_i.take_right) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o   = value_q;
  assign flag_o.ge = (value_q >= key_i);
  assign flag_o.eq = (value_q == key_i);

endmodule

`default_nettype wire
